// File: design/closest_points_two_lines_3d_defines.svh
// Assertion macros used by the checker file of the line closest-point block.
`ifndef CLOSEST_POINTS_TWO_LINES_3D_DEFINES_SVH
`define CLOSEST_POINTS_TWO_LINES_3D_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while reset is asserted.
`define CLP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while reset is asserted.
`define CLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/clp_pkg.sv
// Types and constants of the line closest-point block.
`timescale 1ns / 1ps
package clp_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int DOT_W   = 2 * DIFF_W + 2;
	localparam int PROD_W  = 2 * DOT_W + 1;
	localparam int FRAC_W  = 16;
	localparam int EPS_W   = 16;
	localparam int LIMB_W  = 32;
	localparam int QMAG_W  = COORD_W - 1;
	localparam int MUL_LAT = 3;
	localparam int DIV_LAT = QMAG_W + 2;

	typedef enum logic [1:0] {
		STAT_SOLVED     = 2'd0,
		STAT_DEG_SECOND = 2'd1,
		STAT_DEG_FIRST  = 2'd2,
		STAT_PARALLEL   = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] first_start_x;
		logic signed [COORD_W-1:0] first_start_y;
		logic signed [COORD_W-1:0] first_start_z;
		logic signed [COORD_W-1:0] first_end_x;
		logic signed [COORD_W-1:0] first_end_y;
		logic signed [COORD_W-1:0] first_end_z;
		logic signed [COORD_W-1:0] second_start_x;
		logic signed [COORD_W-1:0] second_start_y;
		logic signed [COORD_W-1:0] second_start_z;
		logic signed [COORD_W-1:0] second_end_x;
		logic signed [COORD_W-1:0] second_end_y;
		logic signed [COORD_W-1:0] second_end_z;
	} lines_t;

	typedef struct packed {
		status_t                   status_code;
		logic signed [COORD_W-1:0] param_first;
		logic signed [COORD_W-1:0] param_second;
		logic signed [COORD_W-1:0] near_first_x;
		logic signed [COORD_W-1:0] near_first_y;
		logic signed [COORD_W-1:0] near_first_z;
		logic signed [COORD_W-1:0] near_second_x;
		logic signed [COORD_W-1:0] near_second_y;
		logic signed [COORD_W-1:0] near_second_z;
	} result_t;

endpackage

// File: design/clp_mul.sv
// Pipelined signed multiplier built from 32 by 32 bit limb products.
`timescale 1ns / 1ps
module clp_mul import clp_pkg::*; #(
	parameter int WA = 33,
	parameter int WB = 33
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [WA-1:0]  a,
	input  logic signed [WB-1:0]  b,
	output logic signed [WA+WB-1:0] p
);

	localparam int NA = (WA + LIMB_W - 1) / LIMB_W;
	localparam int NB = (WB + LIMB_W - 1) / LIMB_W;
	localparam int SW = (NA + NB) * LIMB_W;

	logic [WA-1:0]          mag_a;
	logic [WB-1:0]          mag_b;
	logic [NA*LIMB_W-1:0]   ua;
	logic [NB*LIMB_W-1:0]   ub;
	logic [2*LIMB_W-1:0]    pp_s1 [NA][NB];
	logic                   neg_s1;
	logic [SW-1:0]          acc;
	logic [WA+WB-1:0]       sum_s2;
	logic                   neg_s2;
	logic signed [WA+WB-1:0] p_s3;

	always_comb begin
		mag_a = a[WA-1] ? WA'(-a) : WA'(a);
		mag_b = b[WB-1] ? WB'(-b) : WB'(b);
		ua    = (NA*LIMB_W)'(mag_a);
		ub    = (NB*LIMB_W)'(mag_b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= ua[i*LIMB_W +: LIMB_W] * ub[j*LIMB_W +: LIMB_W];
				end
			end
			neg_s1 <= a[WA-1] ^ b[WB-1];
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (SW'(pp_s1[i][j]) << (LIMB_W * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= acc[WA+WB-1:0];
			neg_s2 <= neg_s1;
			p_s3   <= neg_s2 ? $signed(-sum_s2) : $signed(sum_s2);
		end
	end

	assign p = p_s3;

endmodule

// File: design/clp_div.sv
// Pipelined restoring divider with a 32-bit saturated, truncated quotient.
`timescale 1ns / 1ps
module clp_div import clp_pkg::*; #(
	parameter int WN = 153,
	parameter int WD = 137
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [WN-1:0]      n,
	input  logic signed [WD-1:0]      d,
	output logic signed [COORD_W-1:0] q
);

	localparam int W   = ((WN > WD + QMAG_W) ? WN : (WD + QMAG_W)) + 1;
	localparam int NST = QMAG_W + 1;

	logic [WN-1:0]     mag_n;
	logic [WD-1:0]     mag_d;
	logic [W-1:0]      rem_q [NST];
	logic [W-1:0]      den_q [NST];
	logic [QMAG_W-1:0] quo_q [NST];
	logic              neg_q [NST];
	logic              ovf_q [NST];
	logic signed [COORD_W-1:0] q_q;

	always_comb begin
		mag_n = n[WN-1] ? WN'(-n) : WN'(n);
		mag_d = d[WD-1] ? WD'(-d) : WD'(d);
	end

	// Any quotient of 2^31 or more saturates, so only 31 bits are developed.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= W'(mag_n);
			den_q[0] <= W'(mag_d);
			quo_q[0] <= '0;
			neg_q[0] <= n[WN-1] ^ d[WD-1];
			ovf_q[0] <= W'(mag_n) >= (W'(mag_d) << QMAG_W);
		end
	end

	for (genvar k = 1; k < NST; k++) begin : g_step
		localparam int B = QMAG_W - k;
		logic [W-1:0] trial;
		logic         ge;

		assign trial = den_q[k-1] << B;
		assign ge    = rem_q[k-1] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? rem_q[k-1] - trial : rem_q[k-1];
				quo_q[k] <= quo_q[k-1] | (ge ? (QMAG_W'(1) << B) : QMAG_W'(0));
				den_q[k] <= den_q[k-1];
				neg_q[k] <= neg_q[k-1];
				ovf_q[k] <= ovf_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_q[NST-1]) begin
				q_q <= neg_q[NST-1] ? {1'b1, {QMAG_W{1'b0}}} : {1'b0, {QMAG_W{1'b1}}};
			end else if (neg_q[NST-1]) begin
				q_q <= $signed(-{1'b0, quo_q[NST-1]});
			end else begin
				q_q <= $signed({1'b0, quo_q[NST-1]});
			end
		end
	end

	assign q = q_q;

endmodule

// File: design/closest_points_two_lines_3d.sv
// Top level: closest points of two 3D lines in signed Q16.16, fully pipelined.
//
//   channel   dir   handshake              payload
//   lines     in    lines_valid/stall      lines_t, four endpoints
//   result    out   result_valid/stall     result_t, status, mua, mub, Pa, Pb
//   cfg       in    cfg_valid/cfg_ready    cfg_data, epsilon_threshold
//
// One item enters per cycle unless a held result stalls the pipeline.
// The two 33-stage dividers, for mua and then for mub, sit in series in the pipeline.
// Reset clears the valid bits and sets the tolerance to 7; data registers keep garbage.
// A held result freezes the whole pipeline, and lines_stall rises in the same cycle.
`timescale 1ns / 1ps
module closest_points_two_lines_3d import clp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             lines_valid,
	output logic             lines_stall,
	input  lines_t           lines,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [EPS_W-1:0] cfg_data
);

	localparam int S_IN   = 1;
	localparam int S_DIF  = S_IN + 1;
	localparam int S_DOT  = S_DIF + MUL_LAT + 1;
	localparam int S_PP   = S_DOT + MUL_LAT;
	localparam int S_DN   = S_PP + 1;
	localparam int S_MUA  = S_DN + DIV_LAT;
	localparam int S_MUBP = S_MUA + MUL_LAT;
	localparam int S_MUBN = S_MUBP + 1;
	localparam int S_MUB  = S_MUBN + DIV_LAT;
	localparam int S_PTP  = S_MUB + MUL_LAT;
	localparam int S_OUT  = S_PTP + 1;

	localparam int NDOT    = 5;
	localparam int D1343   = 0;
	localparam int D4321   = 1;
	localparam int D1321   = 2;
	localparam int D4343   = 3;
	localparam int D2121   = 4;
	localparam int DEN_SH  = 3 * FRAC_W;
	localparam int MUBP_W  = DOT_W + COORD_W;
	localparam int MUBN_W  = MUBP_W + 1;
	localparam int PTP_W   = COORD_W + DIFF_W;
	localparam int PT_W    = PTP_W - FRAC_W + 1;
	localparam logic signed [PT_W-1:0] PT_MAX = PT_W'((64'sd1 <<< QMAG_W) - 64'sd1);
	localparam logic signed [PT_W-1:0] PT_MIN = -PT_MAX - PT_W'(1);

	typedef struct packed {
		logic [2:0][COORD_W-1:0] p1;
		logic [2:0][COORD_W-1:0] p3;
		logic [2:0][DIFF_W-1:0]  p13;
		logic [2:0][DIFF_W-1:0]  p43;
		logic [2:0][DIFF_W-1:0]  p21;
	} geo_t;

	function automatic logic is_small(input logic signed [DIFF_W-1:0] v,
			input logic [EPS_W-1:0] e);
		logic signed [DIFF_W:0] ve;
		logic signed [DIFF_W:0] ee;
		ve = (DIFF_W+1)'(v);
		ee = $signed((DIFF_W+1)'(e));
		return (ve < ee) && (ve > -ee);
	endfunction

	function automatic logic [COORD_W-1:0] sat_pt(input logic signed [PT_W-1:0] v);
		if (v > PT_MAX) begin
			return PT_MAX[COORD_W-1:0];
		end else if (v < PT_MIN) begin
			return PT_MIN[COORD_W-1:0];
		end
		return v[COORD_W-1:0];
	endfunction

	logic                     adv;
	logic [S_OUT:1]           vld_q;
	logic [EPS_W-1:0]         eps_q;
	lines_t                   in_s1;
	geo_t                     dif;
	geo_t                     geo_q [S_DIF:S_PTP];
	logic [1:0]               deg_q [S_DIF+1:S_DN];
	logic signed [DIFF_W-1:0] dot_a [NDOT][3];
	logic signed [DIFF_W-1:0] dot_b [NDOT][3];
	logic signed [2*DIFF_W-1:0] dot_p [NDOT][3];
	logic signed [DOT_W-1:0]  dot_s6 [NDOT];
	logic signed [DOT_W-1:0]  d1343_q [S_DOT+1:S_MUBP];
	logic signed [DOT_W-1:0]  d4321_q [S_DOT+1:S_MUA];
	logic signed [DOT_W-1:0]  d4343_q [S_DOT+1:S_MUBN];
	logic signed [2*DOT_W-1:0] m_dd, m_cc, m_nc, m_nd;
	logic signed [PROD_W-1:0] denom_s10;
	logic signed [PROD_W-1:0] numer_s10;
	logic [PROD_W-1:0]        denom_mag;
	logic [PROD_W-1:0]        eps_big;
	status_t                  status_nx;
	status_t                  status_q [S_DN+1:S_PTP];
	logic signed [COORD_W-1:0] mua_w;
	logic signed [COORD_W-1:0] mub_w;
	logic signed [COORD_W-1:0] mua_q [S_MUA+1:S_PTP];
	logic signed [COORD_W-1:0] mub_q [S_MUB+1:S_PTP];
	logic signed [MUBP_W-1:0] mubp;
	logic signed [MUBN_W-1:0] mubn_s47;
	logic signed [PTP_W-1:0]  pa_p [3];
	logic signed [PTP_W-1:0]  pb_p [3];
	logic [2:0][COORD_W-1:0]  pa;
	logic [2:0][COORD_W-1:0]  pb;
	result_t                  res_nx;
	result_t                  res_s84;

	// The pipeline moves as one; only a held result stops it.
	assign adv         = !(vld_q[S_OUT] && result_stall);
	assign lines_stall = !adv;
	assign cfg_ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			eps_q <= EPS_W'(7);
		end else begin
			if (adv) begin
				vld_q <= {vld_q[S_OUT-1:1], lines_valid};
			end
			if (cfg_valid) begin
				eps_q <= cfg_data;
			end
		end
	end

	always_comb begin
		dif.p1  = {in_s1.first_start_z, in_s1.first_start_y, in_s1.first_start_x};
		dif.p3  = {in_s1.second_start_z, in_s1.second_start_y, in_s1.second_start_x};
		dif.p13[0] = DIFF_W'(in_s1.first_start_x) - DIFF_W'(in_s1.second_start_x);
		dif.p13[1] = DIFF_W'(in_s1.first_start_y) - DIFF_W'(in_s1.second_start_y);
		dif.p13[2] = DIFF_W'(in_s1.first_start_z) - DIFF_W'(in_s1.second_start_z);
		dif.p43[0] = DIFF_W'(in_s1.second_end_x) - DIFF_W'(in_s1.second_start_x);
		dif.p43[1] = DIFF_W'(in_s1.second_end_y) - DIFF_W'(in_s1.second_start_y);
		dif.p43[2] = DIFF_W'(in_s1.second_end_z) - DIFF_W'(in_s1.second_start_z);
		dif.p21[0] = DIFF_W'(in_s1.first_end_x) - DIFF_W'(in_s1.first_start_x);
		dif.p21[1] = DIFF_W'(in_s1.first_end_y) - DIFF_W'(in_s1.first_start_y);
		dif.p21[2] = DIFF_W'(in_s1.first_end_z) - DIFF_W'(in_s1.first_start_z);
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			dot_a[D1343][c] = $signed(geo_q[S_DIF].p13[c]);
			dot_b[D1343][c] = $signed(geo_q[S_DIF].p43[c]);
			dot_a[D4321][c] = $signed(geo_q[S_DIF].p43[c]);
			dot_b[D4321][c] = $signed(geo_q[S_DIF].p21[c]);
			dot_a[D1321][c] = $signed(geo_q[S_DIF].p13[c]);
			dot_b[D1321][c] = $signed(geo_q[S_DIF].p21[c]);
			dot_a[D4343][c] = $signed(geo_q[S_DIF].p43[c]);
			dot_b[D4343][c] = $signed(geo_q[S_DIF].p43[c]);
			dot_a[D2121][c] = $signed(geo_q[S_DIF].p21[c]);
			dot_b[D2121][c] = $signed(geo_q[S_DIF].p21[c]);
		end
	end

	for (genvar g = 0; g < NDOT; g++) begin : g_dot
		for (genvar c = 0; c < 3; c++) begin : g_comp
			clp_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_mul (
				.clk (clk),
				.en  (adv),
				.a   (dot_a[g][c]),
				.b   (dot_b[g][c]),
				.p   (dot_p[g][c])
			);
		end
	end

	clp_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_dd (
		.clk (clk), .en (adv), .a (dot_s6[D2121]), .b (dot_s6[D4343]), .p (m_dd));
	clp_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_cc (
		.clk (clk), .en (adv), .a (dot_s6[D4321]), .b (dot_s6[D4321]), .p (m_cc));
	clp_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_nc (
		.clk (clk), .en (adv), .a (dot_s6[D1343]), .b (dot_s6[D4321]), .p (m_nc));
	clp_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_nd (
		.clk (clk), .en (adv), .a (dot_s6[D1321]), .b (dot_s6[D4343]), .p (m_nd));

	always_comb begin
		denom_mag = denom_s10[PROD_W-1] ? PROD_W'(-denom_s10) : PROD_W'(denom_s10);
		eps_big   = PROD_W'(eps_q) << DEN_SH;
		if (deg_q[S_DN][1]) begin
			status_nx = STAT_DEG_SECOND;
		end else if (deg_q[S_DN][0]) begin
			status_nx = STAT_DEG_FIRST;
		end else if (denom_mag == '0 || denom_mag < eps_big) begin
			status_nx = STAT_PARALLEL;
		end else begin
			status_nx = STAT_SOLVED;
		end
	end

	clp_div #(.WN(PROD_W + FRAC_W), .WD(PROD_W)) u_div_mua (
		.clk (clk),
		.en  (adv),
		.n   ($signed({numer_s10, {FRAC_W{1'b0}}})),
		.d   (denom_s10),
		.q   (mua_w)
	);

	clp_mul #(.WA(DOT_W), .WB(COORD_W)) u_mul_mub (
		.clk (clk), .en (adv), .a (d4321_q[S_MUA]), .b (mua_w), .p (mubp));

	clp_div #(.WN(MUBN_W), .WD(DOT_W)) u_div_mub (
		.clk (clk),
		.en  (adv),
		.n   (mubn_s47),
		.d   (d4343_q[S_MUBN]),
		.q   (mub_w)
	);

	for (genvar c = 0; c < 3; c++) begin : g_pt
		clp_mul #(.WA(COORD_W), .WB(DIFF_W)) u_mul_pa (
			.clk (clk), .en (adv), .a (mua_q[S_MUB]),
			.b ($signed(geo_q[S_MUB].p21[c])), .p (pa_p[c]));
		clp_mul #(.WA(COORD_W), .WB(DIFF_W)) u_mul_pb (
			.clk (clk), .en (adv), .a (mub_w),
			.b ($signed(geo_q[S_MUB].p43[c])), .p (pb_p[c]));
		assign pa[c] = sat_pt(PT_W'($signed(geo_q[S_PTP].p1[c])) + PT_W'(pa_p[c] >>> FRAC_W));
		assign pb[c] = sat_pt(PT_W'($signed(geo_q[S_PTP].p3[c])) + PT_W'(pb_p[c] >>> FRAC_W));
	end

	// Any degenerate or parallel case reports zeros beside its status.
	always_comb begin
		res_nx = '0;
		res_nx.status_code = status_q[S_PTP];
		if (status_q[S_PTP] == STAT_SOLVED) begin
			res_nx.param_first   = mua_q[S_PTP];
			res_nx.param_second  = mub_q[S_PTP];
			res_nx.near_first_x  = pa[0];
			res_nx.near_first_y  = pa[1];
			res_nx.near_first_z  = pa[2];
			res_nx.near_second_x = pb[0];
			res_nx.near_second_y = pb[1];
			res_nx.near_second_z = pb[2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1 <= lines;
			geo_q[S_DIF] <= dif;
			for (int k = S_DIF + 1; k <= S_PTP; k++) begin
				geo_q[k] <= geo_q[k-1];
			end

			deg_q[S_DIF+1] <= {
				is_small($signed(geo_q[S_DIF].p43[0]), eps_q) &&
				is_small($signed(geo_q[S_DIF].p43[1]), eps_q) &&
				is_small($signed(geo_q[S_DIF].p43[2]), eps_q),
				is_small($signed(geo_q[S_DIF].p21[0]), eps_q) &&
				is_small($signed(geo_q[S_DIF].p21[1]), eps_q) &&
				is_small($signed(geo_q[S_DIF].p21[2]), eps_q)};
			for (int k = S_DIF + 2; k <= S_DN; k++) begin
				deg_q[k] <= deg_q[k-1];
			end

			for (int g = 0; g < NDOT; g++) begin
				dot_s6[g] <= DOT_W'(dot_p[g][0]) + DOT_W'(dot_p[g][1]) + DOT_W'(dot_p[g][2]);
			end
			d1343_q[S_DOT+1] <= dot_s6[D1343];
			d4321_q[S_DOT+1] <= dot_s6[D4321];
			d4343_q[S_DOT+1] <= dot_s6[D4343];
			for (int k = S_DOT + 2; k <= S_MUBP; k++) begin
				d1343_q[k] <= d1343_q[k-1];
			end
			for (int k = S_DOT + 2; k <= S_MUA; k++) begin
				d4321_q[k] <= d4321_q[k-1];
			end
			for (int k = S_DOT + 2; k <= S_MUBN; k++) begin
				d4343_q[k] <= d4343_q[k-1];
			end

			denom_s10 <= PROD_W'(m_dd) - PROD_W'(m_cc);
			numer_s10 <= PROD_W'(m_nc) - PROD_W'(m_nd);

			status_q[S_DN+1] <= status_nx;
			for (int k = S_DN + 2; k <= S_PTP; k++) begin
				status_q[k] <= status_q[k-1];
			end

			mua_q[S_MUA+1] <= mua_w;
			for (int k = S_MUA + 2; k <= S_PTP; k++) begin
				mua_q[k] <= mua_q[k-1];
			end
			mub_q[S_MUB+1] <= mub_w;
			for (int k = S_MUB + 2; k <= S_PTP; k++) begin
				mub_q[k] <= mub_q[k-1];
			end

			mubn_s47 <= MUBN_W'(mubp) + (MUBN_W'(d1343_q[S_MUBP]) <<< FRAC_W);

			res_s84 <= res_nx;
		end
	end

	assign result_valid = vld_q[S_OUT];
	assign result       = res_s84;

endmodule

// File: design/clp_check.sv
// Port-level checks of the line closest-point block, bound to the top level.
`timescale 1ns / 1ps
`include "closest_points_two_lines_3d_defines.svh"
module clp_check import clp_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             lines_valid,
	input logic             lines_stall,
	input lines_t           lines,
	input logic             result_valid,
	input logic             result_stall,
	input result_t          result,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic [EPS_W-1:0] cfg_data
);

	// A held result keeps its value until the transfer completes.
	`CLP_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "result changed while stalled")

	// The input side stalls exactly when a finished result is held back.
	`CLP_ASSERT_NOW(a_stall_link, 1'b1, lines_stall == (result_valid && result_stall), "input stall does not follow output stall")

	// A failed solve reports nothing but its status.
	`CLP_ASSERT_NOW(a_fail_zero, result_valid && result.status_code != STAT_SOLVED, result.param_first == '0 && result.param_second == '0 && result.near_first_x == '0 && result.near_first_y == '0 && result.near_first_z == '0 && result.near_second_x == '0 && result.near_second_y == '0 && result.near_second_z == '0, "nonzero fields beside a failure status")

	// The tolerance register always takes a write.
	`CLP_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind closest_points_two_lines_3d clp_check u_clp_check (.*);
